FILE: rtl/jsu_pkg.sv
// Shared types, codes and helpers for the JSON string unescape block.
`default_nettype none
package jsu_pkg;

  localparam int LINE_BITS_DEF = 16;
  localparam int LINE_OUT_W    = 16;
  localparam int UNIT_W        = 16;
  localparam int ERR_W         = 3;
  localparam int MODE_W        = 2;

  // Decoder modes.
  localparam logic [MODE_W-1:0] MODE_WAIT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BODY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ESC  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HEX  = 2'd3;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NO_OPEN  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NO_CLOSE = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_HEX  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BAD_ESC  = 3'd4;

  // Code units of interest.
  localparam logic [UNIT_W-1:0] CU_QUOTE   = 16'h0022;
  localparam logic [UNIT_W-1:0] CU_BSLASH  = 16'h005C;
  localparam logic [UNIT_W-1:0] CU_SLASH   = 16'h002F;
  localparam logic [UNIT_W-1:0] CU_LF      = 16'h000A;
  localparam logic [UNIT_W-1:0] CU_CR      = 16'h000D;
  localparam logic [UNIT_W-1:0] CU_TAB     = 16'h0009;
  localparam logic [UNIT_W-1:0] CU_BS      = 16'h0008;
  localparam logic [UNIT_W-1:0] CU_FF      = 16'h000C;
  localparam logic [UNIT_W-1:0] CU_LOW_B   = 16'h0062;
  localparam logic [UNIT_W-1:0] CU_LOW_F   = 16'h0066;
  localparam logic [UNIT_W-1:0] CU_LOW_N   = 16'h006E;
  localparam logic [UNIT_W-1:0] CU_LOW_R   = 16'h0072;
  localparam logic [UNIT_W-1:0] CU_LOW_T   = 16'h0074;
  localparam logic [UNIT_W-1:0] CU_LOW_U   = 16'h0075;

  typedef struct packed {
    logic              char_valid;
    logic [UNIT_W-1:0] decoded_char;
    logic              string_done;
    logic [ERR_W-1:0]  error_code;
  } jsu_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } jsu_hex_t;

  // Hex digit of either case; ok is low for anything else.
  function automatic jsu_hex_t hex_digit(input logic [UNIT_W-1:0] u);
    jsu_hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (u >= 16'h0030 && u <= 16'h0039) begin
      h.val = u[3:0];
    end else if ((u >= 16'h0061 && u <= 16'h0066) || (u >= 16'h0041 && u <= 16'h0046)) begin
      h.val = u[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/jsu_line_cnt.sv
// Saturating line counter, reported after each transaction's update.
`default_nettype none
module jsu_line_cnt
  import jsu_pkg::*;
#(
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  inc,
  output logic [LINE_OUT_W-1:0]      line_o
);

  logic [LINE_BITS-1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (inc && cnt_r != {LINE_BITS{1'b1}}) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= LINE_BITS'(1);
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // A counter wider than the report clamps at the report's maximum.
  generate
    if (LINE_BITS > LINE_OUT_W) begin : g_clamp
      assign line_o = (|cnt_nxt[LINE_BITS-1:LINE_OUT_W]) ? {LINE_OUT_W{1'b1}}
                                                          : cnt_nxt[LINE_OUT_W-1:0];
    end else begin : g_ext
      assign line_o = LINE_OUT_W'(cnt_nxt);
    end
  endgenerate

endmodule
`default_nettype wire

FILE: rtl/jsu_decode.sv
// Unescape state and per-unit decode logic.
`default_nettype none
module jsu_decode
  import jsu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic [UNIT_W-1:0] unit,
  input  wire logic              at_end,
  output jsu_result_t            res
);

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [1:0]        hex_cnt_r, hex_cnt_nxt;
  logic [UNIT_W-1:0] hex_acc_r, hex_acc_nxt;
  logic [UNIT_W-1:0] eff_unit;
  logic [UNIT_W-1:0] acc_shift;
  jsu_hex_t          hx;

  // A missing unit after a backslash or inside hex digits reads as zero.
  assign eff_unit  = at_end ? '0 : unit;
  assign hx        = hex_digit(eff_unit);
  assign acc_shift = {hex_acc_r[UNIT_W-5:0], hx.val};

  always_comb begin
    res         = '0;
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    hex_acc_nxt = hex_acc_r;
    case (mode_r)
      MODE_WAIT: begin
        if (!at_end && unit == CU_QUOTE) begin
          mode_nxt = MODE_BODY;
        end else begin
          res.error_code = ERR_NO_OPEN;
        end
      end
      MODE_BODY: begin
        if (at_end) begin
          res.error_code = ERR_NO_CLOSE;
        end else if (unit == CU_QUOTE) begin
          res.string_done = 1'b1;
          mode_nxt        = MODE_WAIT;
        end else if (unit == CU_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          res.char_valid   = 1'b1;
          res.decoded_char = unit;
        end
      end
      MODE_ESC: begin
        mode_nxt       = MODE_BODY;
        res.char_valid = 1'b1;
        case (eff_unit)
          CU_QUOTE:  res.decoded_char = CU_QUOTE;
          CU_BSLASH: res.decoded_char = CU_BSLASH;
          CU_SLASH:  res.decoded_char = CU_SLASH;
          CU_LOW_B:  res.decoded_char = CU_BS;
          CU_LOW_F:  res.decoded_char = CU_FF;
          CU_LOW_N:  res.decoded_char = CU_LF;
          CU_LOW_R:  res.decoded_char = CU_CR;
          CU_LOW_T:  res.decoded_char = CU_TAB;
          CU_LOW_U: begin
            res.char_valid = 1'b0;
            mode_nxt       = MODE_HEX;
            hex_cnt_nxt    = 2'd0;
            hex_acc_nxt    = '0;
          end
          default: begin
            res.char_valid = 1'b0;
            res.error_code = ERR_BAD_ESC;
          end
        endcase
      end
      default: begin
        if (!hx.ok) begin
          res.error_code = ERR_BAD_HEX;
        end else if (hex_cnt_r == 2'd3) begin
          res.char_valid   = 1'b1;
          res.decoded_char = acc_shift;
          hex_cnt_nxt      = 2'd0;
          hex_acc_nxt      = '0;
          mode_nxt         = MODE_BODY;
        end else begin
          hex_acc_nxt = acc_shift;
          hex_cnt_nxt = hex_cnt_r + 2'd1;
        end
      end
    endcase
    if (res.error_code != ERR_NONE) begin
      mode_nxt    = MODE_WAIT;
      hex_cnt_nxt = 2'd0;
      hex_acc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_WAIT;
      hex_cnt_r <= 2'd0;
      hex_acc_r <= '0;
    end else if (advance) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      hex_acc_r <= hex_acc_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/json_string_unescape_core.sv
// JSON string unescape: one UTF-16 code unit per unstalled cycle, each decoded.
// Input channel: in_valid / in_stall carry in_code_unit and in_at_end. A
// transaction is taken at a rising edge with in_valid high and in_stall low.
// Every input transaction gives exactly one output transaction on out_valid /
// out_stall: a decoded unit (out_char_valid), a closing quote (out_string_done),
// an error code, and the line number after that unit.
// The unit lands in the input register at the accepting edge; its result goes to
// the output register, raising out_valid, if that register is empty or unstalled.
// Throughput is one unit per cycle while out_stall is low, set by the single
// decode step between the two registers that also updates the mode and hex state.
// When the receiver stalls, the result holds in the output register; one more
// unit waits in the input register and in_stall rises only once both are full.
// Synchronous reset (rst_n low) empties both registers, returns the decoder to
// waiting for an opening quote with cleared hex state, and sets the line
// count to one.
`default_nettype none
module json_string_unescape_core
  import jsu_pkg::*;
#(
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [UNIT_W-1:0]     in_code_unit,
  input  wire logic                  in_at_end,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_char_valid,
  output logic [UNIT_W-1:0]          out_decoded_char,
  output logic                       out_string_done,
  output logic [ERR_W-1:0]           out_error_code,
  output logic [LINE_OUT_W-1:0]      out_line_number
);

  logic              in_v_r, in_v_nxt;
  logic [UNIT_W-1:0] unit_r;
  logic              end_r;
  logic              out_v_r, out_v_nxt;
  jsu_result_t       res_r, res;
  logic [LINE_OUT_W-1:0] line_r, line_val;
  logic              advance;
  logic              load;

  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign load     = in_valid && !in_stall;

  assign in_v_nxt  = load || (in_v_r && !advance);
  assign out_v_nxt = advance || (out_v_r && out_stall);

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .unit    (unit_r),
    .at_end  (end_r),
    .res     (res)
  );

  jsu_line_cnt #(
    .LINE_BITS (LINE_BITS)
  ) u_line_cnt (
    .clk    (clk),
    .rst_n  (rst_n),
    .inc    (advance && !end_r && unit_r == CU_LF),
    .line_o (line_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unit_r <= in_code_unit;
      end_r  <= in_at_end;
    end
    if (advance) begin
      res_r  <= res;
      line_r <= line_val;
    end
  end

  assign out_valid        = out_v_r;
  assign out_char_valid   = res_r.char_valid;
  assign out_decoded_char = res_r.decoded_char;
  assign out_string_done  = res_r.string_done;
  assign out_error_code   = res_r.error_code;
  assign out_line_number  = line_r;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_v_r)
    else $error("input stalled with an empty input register");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("decoded unit did not reach the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall) |-> !advance)
    else $error("stalled result overwritten");

  a_error_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.error_code != ERR_NONE) |-> (!res_r.char_valid && !res_r.string_done))
    else $error("error result also carries a unit or a closing quote");
`endif

endmodule
`default_nettype wire

FILE: tb/json_string_unescape_core_tb.sv
// Self-checking testbench for the JSON string unescape core.
`timescale 1ns / 1ps
module json_string_unescape_core_tb
  import jsu_pkg::*;
();

  typedef struct packed {
    logic              char_valid;
    logic [UNIT_W-1:0] decoded_char;
    logic              string_done;
    logic [ERR_W-1:0]  error_code;
    logic [15:0]       line_number;
  } decode_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [UNIT_W-1:0]     in_code_unit;
  logic                  in_at_end;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_char_valid;
  logic [UNIT_W-1:0]     out_decoded_char;
  logic                  out_string_done;
  logic [ERR_W-1:0]      out_error_code;
  logic [LINE_OUT_W-1:0] out_line_number;

  // Predictor state.
  logic [MODE_W-1:0] esc_mode;
  logic [1:0]        digits_taken;
  logic [15:0]       code_acc;
  logic [15:0]       lines_seen;

  decode_result_t pending_results[$];
  int  errors;
  int  units_sent;
  bit  idle_en;
  int  stall_left;

  json_string_unescape_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_code_unit     (in_code_unit),
    .in_at_end        (in_at_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char_valid   (out_char_valid),
    .out_decoded_char (out_decoded_char),
    .out_string_done  (out_string_done),
    .out_error_code   (out_error_code),
    .out_line_number  (out_line_number)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_nibble(input logic [15:0] u);
    if (u >= 16'h0030 && u <= 16'h0039) return {1'b1, 4'(u - 16'h0030)};
    if (u >= 16'h0061 && u <= 16'h0066) return {1'b1, 4'(u - 16'h0061 + 16'd10)};
    if (u >= 16'h0041 && u <= 16'h0046) return {1'b1, 4'(u - 16'h0041 + 16'd10)};
    return 5'd0;
  endfunction

  function automatic logic [15:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 16'h0030 + 16'(n);
    return (upper ? 16'h0041 : 16'h0061) + 16'(n) - 16'd10;
  endfunction

  function automatic decode_result_t decode_unit(input logic [15:0] u, input logic e);
    decode_result_t r;
    logic [15:0]    eff;
    logic [16:0]    mapped;
    logic [4:0]     dig;
    r = '0;
    eff = e ? 16'h0000 : u;
    if (!e && u == CU_LF && lines_seen != 16'hFFFF) lines_seen++;
    case (esc_mode)
      MODE_WAIT: begin
        if (!e && u == CU_QUOTE) esc_mode = MODE_BODY;
        else r.error_code = ERR_NO_OPEN;
      end
      MODE_BODY: begin
        if (e) begin
          r.error_code = ERR_NO_CLOSE;
        end else if (u == CU_QUOTE) begin
          r.string_done = 1'b1;
          esc_mode = MODE_WAIT;
        end else if (u == CU_BSLASH) begin
          esc_mode = MODE_ESC;
        end else begin
          r.char_valid = 1'b1;
          r.decoded_char = u;
        end
      end
      MODE_ESC: begin
        case (eff)
          CU_QUOTE, CU_BSLASH, CU_SLASH: mapped = {1'b1, eff};
          CU_LOW_B: mapped = {1'b1, CU_BS};
          CU_LOW_F: mapped = {1'b1, CU_FF};
          CU_LOW_N: mapped = {1'b1, CU_LF};
          CU_LOW_R: mapped = {1'b1, CU_CR};
          CU_LOW_T: mapped = {1'b1, CU_TAB};
          default:  mapped = '0;
        endcase
        if (eff == CU_LOW_U) begin
          esc_mode = MODE_HEX;
          digits_taken = 2'd0;
          code_acc = 16'd0;
        end else if (mapped[16]) begin
          r.char_valid = 1'b1;
          r.decoded_char = mapped[15:0];
          esc_mode = MODE_BODY;
        end else begin
          r.error_code = ERR_BAD_ESC;
        end
      end
      default: begin
        dig = hex_nibble(eff);
        if (!dig[4]) begin
          r.error_code = ERR_BAD_HEX;
        end else begin
          code_acc = {code_acc[11:0], dig[3:0]};
          if (digits_taken == 2'd3) begin
            r.char_valid = 1'b1;
            r.decoded_char = code_acc;
            digits_taken = 2'd0;
            code_acc = 16'd0;
            esc_mode = MODE_BODY;
          end else begin
            digits_taken++;
          end
        end
      end
    endcase
    if (r.error_code != ERR_NONE) begin
      esc_mode = MODE_WAIT;
      digits_taken = 2'd0;
      code_acc = 16'd0;
    end
    r.line_number = lines_seen;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_unit(input logic [15:0] u, input logic e = 1'b0);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_code_unit <= u;
    in_at_end    <= e;
    do @(posedge clk); while (in_stall);
    pending_results.insert(pending_results.size(), decode_unit(u, e));
    units_sent++;
    @(negedge clk);
  endtask

  task automatic push_end();
    push_unit(16'($urandom()), 1'b1);
  endtask

  // Stop sending until every expected transaction has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk);
  endtask

  function automatic logic [15:0] random_plain();
    logic [15:0] u;
    case ($urandom_range(0, 5))
      0, 1:    u = 16'($urandom());
      2:       u = CU_LF;
      default: u = 16'($urandom_range(16'h0020, 16'h007E));
    endcase
    if (u == CU_QUOTE || u == CU_BSLASH) u = u ^ 16'h0100;
    return u;
  endfunction

  function automatic logic [15:0] random_escape();
    case ($urandom_range(0, 7))
      0: return CU_QUOTE;
      1: return CU_BSLASH;
      2: return CU_SLASH;
      3: return CU_LOW_B;
      4: return CU_LOW_F;
      5: return CU_LOW_N;
      6: return CU_LOW_R;
      default: return CU_LOW_T;
    endcase
  endfunction

  // Units just outside the digit ranges, or anything at all.
  function automatic logic [15:0] random_bad_hex();
    case ($urandom_range(0, 6))
      0: return 16'h002F;
      1: return 16'h003A;
      2: return 16'h0040;
      3: return 16'h0047;
      4: return 16'h0060;
      5: return 16'h0067;
      default: return 16'($urandom());
    endcase
  endfunction

  // One string with random content; now and then it is broken on purpose.
  task automatic push_random_string();
    int          segs;
    int          broken_at;
    logic [15:0] u;
    segs = int'($urandom_range(0, 10));
    broken_at = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, segs)) : -1;
    push_unit(CU_QUOTE);
    for (int s = 0; s < segs; s++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          if (s == broken_at) begin
            push_end();
            return;
          end
          push_unit(random_plain());
        end
        5, 6, 7: begin
          push_unit(CU_BSLASH);
          if (s == broken_at) begin
            if ($urandom_range(0, 3) == 0) push_end();
            else push_unit(16'($urandom()));
            return;
          end
          push_unit(random_escape());
        end
        default: begin
          push_unit(CU_BSLASH);
          push_unit(CU_LOW_U);
          for (int d = 0; d < 4; d++) begin
            if (s == broken_at && d == $urandom_range(d, 3)) begin
              if ($urandom_range(0, 3) == 0) push_end();
              else push_unit(random_bad_hex());
              return;
            end
            u = hex_char(4'($urandom()), 1'($urandom()));
            push_unit(u);
          end
        end
      endcase
    end
    if ($urandom_range(0, 15) == 0) push_end();
    else push_unit(CU_QUOTE);
  endtask

  task automatic test_wait_errors();
    push_end();
    push_unit(CU_LF);
    push_unit(16'hFFFF);
    push_unit(16'h0000);
  endtask

  task automatic test_plain_and_escapes();
    push_unit(CU_QUOTE);
    push_unit(16'h0000);
    push_unit(16'hFFFF);
    push_unit(CU_LF);
    for (int k = 0; k < 8; k++) begin
      push_unit(CU_BSLASH);
      case (k)
        0: push_unit(CU_QUOTE);
        1: push_unit(CU_BSLASH);
        2: push_unit(CU_SLASH);
        3: push_unit(CU_LOW_B);
        4: push_unit(CU_LOW_F);
        5: push_unit(CU_LOW_N);
        6: push_unit(CU_LOW_R);
        default: push_unit(CU_LOW_T);
      endcase
    end
    // Digits 0, 9 and both ends of both letter ranges.
    push_unit(CU_BSLASH);
    push_unit(CU_LOW_U);
    push_unit(hex_char(4'h0, 1'b0));
    push_unit(hex_char(4'ha, 1'b0));
    push_unit(hex_char(4'hF, 1'b1));
    push_unit(hex_char(4'h9, 1'b0));
    push_unit(CU_BSLASH);
    push_unit(CU_LOW_U);
    push_unit(hex_char(4'hA, 1'b1));
    push_unit(hex_char(4'hf, 1'b0));
    push_unit(hex_char(4'hf, 1'b0));
    push_unit(hex_char(4'hf, 1'b0));
    push_unit(CU_QUOTE);
  endtask

  task automatic test_broken_strings();
    push_unit(CU_QUOTE);
    push_end();
    push_unit(CU_QUOTE);
    push_unit(CU_BSLASH);
    push_end();
    push_unit(CU_QUOTE);
    push_unit(CU_BSLASH);
    push_unit(16'h0078);
    push_unit(CU_QUOTE);
    push_unit(CU_BSLASH);
    push_unit(CU_LOW_U);
    push_unit(hex_char(4'h1, 1'b0));
    push_end();
    push_unit(CU_QUOTE);
    push_unit(CU_BSLASH);
    push_unit(CU_LOW_U);
    push_unit(16'h0047);
  endtask

  task automatic test_random_strings(input int target);
    target += units_sent;
    while (units_sent < target) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 3) == 0) push_end();
          else push_unit(16'($urandom()));
        end
      end
      push_random_string();
    end
  endtask

  // A long run of newlines inside one string, then one while waiting.
  task automatic test_newline_run();
    push_unit(CU_QUOTE);
    repeat (64) push_unit(CU_LF);
    push_unit(CU_QUOTE);
    push_unit(CU_LF);
  endtask

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    decode_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual char %h err %0d",
                 $time, out_decoded_char, out_error_code);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("char_valid", 16'(exp_r.char_valid), 16'(out_char_valid));
        check_field("decoded_char", exp_r.decoded_char, out_decoded_char);
        check_field("string_done", 16'(exp_r.string_done), 16'(out_string_done));
        check_field("error_code", 16'(exp_r.error_code), 16'(out_error_code));
        check_field("line_number", exp_r.line_number, out_line_number);
      end
    end
  end

  // Receiver stalls in random bursts while idling is enabled.
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!idle_en) stall_left = 0;
      else if (stall_left == 0 && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_code_unit = '0;
    in_at_end    = 1'b0;
    idle_en      = 1'b1;
    errors       = 0;
    units_sent   = 0;
    esc_mode     = MODE_WAIT;
    digits_taken = 2'd0;
    code_acc     = 16'd0;
    lines_seen   = 16'd1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_wait_errors();
    test_plain_and_escapes();
    test_broken_strings();
    test_random_strings(650);
    drain_results();
    idle_en = 1'b0;
    test_newline_run();
    test_random_strings(150);

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: json_string_unescape_core.f
rtl/jsu_pkg.sv
rtl/jsu_line_cnt.sv
rtl/jsu_decode.sv
rtl/json_string_unescape_core.sv
tb/json_string_unescape_core_tb.sv
